FILE: src/eroded_mask_sample_normalizer_unit_macros.svh
// Assertion helpers shared by the block's modules.
// All checks sample on the rising clock and are off while reset is high.
`ifndef ERODED_MASK_SAMPLE_NORMALIZER_UNIT_MACROS_SVH
`define ERODED_MASK_SAMPLE_NORMALIZER_UNIT_MACROS_SVH

// same-cycle implication
`define EMSN_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EMSN_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/emsn_pkg.sv
`default_nettype none
package emsn_pkg;

   // sizing
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_EROSION = 4;
   localparam int VALUE_BITS  = 24;

   localparam int COL_BITS    = 10;
   localparam int ROW_BITS    = 12;
   localparam int HIST_BITS   = 2 * MAX_EROSION;
   localparam int WIN_COLS    = 2 * MAX_EROSION + 1;
   localparam int DELAY_DEPTH = MAX_EROSION * MAX_WIDTH + MAX_EROSION;
   localparam int PTR_BITS    = $clog2(DELAY_DEPTH);
   localparam int FADDR_BITS  = $clog2(MAX_WIDTH);
   localparam int NORM_BITS   = 16;
   localparam int DIV_BITS    = 28;
   localparam int STEP_BITS   = $clog2(DIV_BITS);
   localparam int QUEUE_DEPTH = 2;

   // register map
   localparam int CSR_ADDR_BITS = 5;
   localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] REG_EROSION      = 3'd2;
   localparam logic [2:0] REG_CENTER_X     = 3'd3;
   localparam logic [2:0] REG_CENTER_Y     = 3'd4;
   localparam logic [2:0] REG_RADIUS       = 3'd5;

   typedef struct packed {
      logic [10:0] frame_width;
      logic [11:0] frame_height;
      logic [2:0]  erosion;
      logic [11:0] center_x;
      logic [12:0] center_y;
      logic [12:0] radius;
   } cfg_type;

   // one core pixel waiting for normalization
   typedef struct packed {
      logic [COL_BITS-1:0]          col;
      logic [ROW_BITS-1:0]          row;
      logic signed [VALUE_BITS-1:0] value;
   } sample_type;

endpackage
`default_nettype wire

FILE: src/emsn_if.sv
`default_nettype none
interface emsn_req_if;
   import emsn_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         pixel_valid;
   logic signed [VALUE_BITS-1:0] phase_value;
   modport source (output valid, pixel_valid, phase_value, input ready);
   modport sink   (input valid, pixel_valid, phase_value, output ready);
endinterface

interface emsn_rsp_if;
   import emsn_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [NORM_BITS-1:0]  norm_x;
   logic signed [NORM_BITS-1:0]  norm_y;
   logic signed [VALUE_BITS-1:0] sample_value;
   logic [COL_BITS-1:0]          col;
   logic [ROW_BITS-1:0]          row;
   modport source (output valid, norm_x, norm_y, sample_value, col, row, input ready);
   modport sink   (input valid, norm_x, norm_y, sample_value, col, row, output ready);
endinterface
`default_nettype wire

FILE: src/emsn_ram.sv
`default_nettype none
module emsn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: src/emsn_front.sv
`default_nettype none
`include "eroded_mask_sample_normalizer_unit_macros.svh"
module emsn_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire emsn_pkg::cfg_type  cfg,
   emsn_req_if.sink                req_port,
   input  wire logic               queue_has_room,
   output logic                    push,
   output emsn_pkg::sample_type    push_data
);
   import emsn_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic state_ff, state_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [PTR_BITS-1:0] ptr_ff, ptr_in;
   logic [WIN_COLS-1:0] win_ff [WIN_COLS];
   logic [WIN_COLS-1:0] win_in [WIN_COLS];

   // word under work
   logic [COL_BITS-1:0]          x_ff;
   logic [ROW_BITS-1:0]          y_ff;
   logic                         pv_ff;
   logic signed [VALUE_BITS-1:0] val_ff;

   logic [10:0] w;
   logic [11:0] h;
   logic [2:0]  e;
   logic [COL_BITS-1:0] x;
   logic [ROW_BITS-1:0] y;
   logic [PTR_BITS-1:0] delay;
   logic [PTR_BITS:0]   rd_sum;
   logic [PTR_BITS-1:0] rd_addr;
   logic accept;

   logic [HIST_BITS-1:0]  flag_rdata;
   logic [VALUE_BITS-1:0] delay_rdata;
   logic [WIN_COLS-1:0]   colbits;
   logic [WIN_COLS-1:0]   need;
   logic core, in_range, working;
   logic [COL_BITS:0]   x_next;
   logic [ROW_BITS:0]   y_next;

   // effective geometry
   always_comb begin
      if (cfg.frame_width == 11'd0) begin
         w = 11'd1;
      end else if (cfg.frame_width > 11'(MAX_WIDTH)) begin
         w = 11'(MAX_WIDTH);
      end else begin
         w = cfg.frame_width;
      end
      h = (cfg.frame_height == 12'd0) ? 12'd1 : cfg.frame_height;
      e = (cfg.erosion > 3'(MAX_EROSION)) ? 3'(MAX_EROSION) : cfg.erosion;
   end

   assign x = ({1'b0, col_ff} >= w) ? '0 : col_ff;
   assign y = (row_ff >= h) ? '0 : row_ff;

   // delayed value sits e rows and e columns back
   assign delay   = PTR_BITS'(e * w + 14'(e));
   assign rd_sum  = (PTR_BITS+1)'(ptr_ff) + (PTR_BITS+1)'(DELAY_DEPTH)
                    - (PTR_BITS+1)'(delay);
   assign rd_addr = (rd_sum >= (PTR_BITS+1)'(DELAY_DEPTH))
                    ? PTR_BITS'(rd_sum - (PTR_BITS+1)'(DELAY_DEPTH))
                    : PTR_BITS'(rd_sum);

   assign req_port.ready = (state_ff == ST_IDLE) && queue_has_room;
   assign accept  = req_port.valid && req_port.ready;
   assign working = (state_ff == ST_READ);

   emsn_ram #(.WIDTH(HIST_BITS), .DEPTH(MAX_WIDTH)) u_flag_ram (
      .clock   (clock),
      .wr_en   (working),
      .wr_addr (FADDR_BITS'(x_ff)),
      .wr_data (colbits[HIST_BITS-1:0]),
      .rd_addr (FADDR_BITS'(x)),
      .rd_data (flag_rdata)
   );

   emsn_ram #(.WIDTH(VALUE_BITS), .DEPTH(DELAY_DEPTH)) u_delay_ram (
      .clock   (clock),
      .wr_en   (working),
      .wr_addr (ptr_ff),
      .wr_data (val_ff),
      .rd_addr (rd_addr),
      .rd_data (delay_rdata)
   );

   // column history, newest row in bit 0
   assign colbits = {flag_rdata, pv_ff};

   // window shift and core test
   always_comb begin
      win_in[0] = colbits;
      for (int k = 1; k < WIN_COLS; k++) begin
         win_in[k] = win_ff[k-1];
      end
      for (int k = 0; k < WIN_COLS; k++) begin
         need[k] = (k <= 2 * int'(e));
      end
      core = 1'b1;
      for (int k = 0; k < WIN_COLS; k++) begin
         if (need[k] && ((win_in[k] & need) != need)) begin
            core = 1'b0;
         end
      end
   end

   assign in_range = (x_ff >= COL_BITS'({e, 1'b0})) && (y_ff >= ROW_BITS'({e, 1'b0}));
   assign push     = working && in_range && core;
   assign push_data.col   = x_ff - COL_BITS'(e);
   assign push_data.row   = y_ff - ROW_BITS'(e);
   assign push_data.value = (delay == '0) ? val_ff : delay_rdata;

   // raster counters and pointer
   assign x_next = {1'b0, x_ff} + 1'b1;
   assign y_next = {1'b0, y_ff} + 1'b1;

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      ptr_in   = ptr_ff;
      if (accept) begin
         state_in = ST_READ;
      end
      if (working) begin
         state_in = ST_IDLE;
         ptr_in   = (ptr_ff == PTR_BITS'(DELAY_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
         if (x_next >= (COL_BITS+1)'(w)) begin
            col_in = '0;
            row_in = (y_next >= (ROW_BITS+1)'(h)) ? '0 : y_next[ROW_BITS-1:0];
         end else begin
            col_in = x_next[COL_BITS-1:0];
            row_in = y_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         ptr_ff   <= '0;
         for (int k = 0; k < WIN_COLS; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         ptr_ff   <= ptr_in;
         if (working) begin
            for (int k = 0; k < WIN_COLS; k++) begin
               win_ff[k] <= win_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff   <= x;
         y_ff   <= y;
         pv_ff  <= req_port.pixel_valid;
         val_ff <= req_port.phase_value;
      end
   end

   `EMSN_ASSERT_NEXT(a_read_one_cycle, state_ff == ST_READ, state_ff == ST_IDLE, "front stuck in read")
   `EMSN_ASSERT_NOW(a_push_room, push, queue_has_room, "front pushed into a full queue")
endmodule
`default_nettype wire

FILE: src/emsn_queue.sv
`default_nettype none
`include "eroded_mask_sample_normalizer_unit_macros.svh"
module emsn_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire emsn_pkg::sample_type push_data,
   input  wire logic              pop,
   output logic                   has_room,
   output logic                   not_empty,
   output emsn_pkg::sample_type   pop_data
);
   import emsn_pkg::*;

   localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

   sample_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign has_room  = count_ff < QCNT_BITS'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `EMSN_ASSERT_NOW(a_no_underflow, pop, not_empty, "queue popped while empty")
   `EMSN_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= QCNT_BITS'(QUEUE_DEPTH), "queue count overrun")
endmodule
`default_nettype wire

FILE: src/emsn_back.sv
`default_nettype none
`include "eroded_mask_sample_normalizer_unit_macros.svh"
module emsn_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire emsn_pkg::cfg_type    cfg,
   input  wire logic                 q_not_empty,
   input  wire emsn_pkg::sample_type q_data,
   output logic                      pop,
   emsn_rsp_if.source                rsp_port
);
   import emsn_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       phase_ff, phase_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;

   // payload registers
   sample_type item_ff;
   logic [DIV_BITS-1:0]  quo_ff;
   logic [13:0]          rem_ff;
   logic                 neg_ff, zero_ff;
   logic [NORM_BITS-1:0] normx_ff, normy_ff;
   logic [NORM_BITS-1:0] out_nx_ff, out_ny_ff;
   sample_type           out_item_ff;

   logic [11:0] pos;
   logic [12:0] centre;
   logic signed [14:0] diff;
   logic [12:0] mag;
   logic [DIV_BITS-1:0] num;
   logic [13:0] divisor;
   logic [14:0] rem_sh;
   logic        ge;
   logic [13:0] rem_next;
   logic [DIV_BITS-1:0] quo_next;
   logic [16:0] m;
   logic [NORM_BITS-1:0] res;
   logic load_out, last_step;

   // numerator setup: |2p - c| * 16384, rounding term folded in
   always_comb begin
      pos    = phase_ff ? item_ff.row : 12'(item_ff.col);
      centre = phase_ff ? cfg.center_y : 13'(cfg.center_x);
      diff   = $signed({2'b00, pos, 1'b0}) - $signed({2'b00, centre});
      mag    = diff[14] ? 13'(-diff) : 13'(diff);
      num    = {1'b0, mag, 14'd0} + DIV_BITS'(cfg.radius);
   end

   // restoring divide step by 2*radius
   assign divisor  = {cfg.radius, 1'b0};
   assign rem_sh   = {rem_ff, quo_ff[DIV_BITS-1]};
   assign ge       = rem_sh >= {1'b0, divisor};
   assign rem_next = ge ? 14'(rem_sh - {1'b0, divisor}) : rem_sh[13:0];
   assign quo_next = {quo_ff[DIV_BITS-2:0], ge};
   assign last_step = (step_ff == STEP_BITS'(DIV_BITS - 1));

   // rounding done, now saturate
   always_comb begin
      m = (quo_next > DIV_BITS'(32768)) ? 17'd32768 : 17'(quo_next);
      if (cfg.radius == 13'd0) begin
         res = zero_ff ? '0 : (neg_ff ? 16'h8000 : 16'h7FFF);
      end else if (neg_ff) begin
         res = 16'(-m);
      end else begin
         res = (m > 17'd32767) ? 16'h7FFF : m[15:0];
      end
   end

   assign pop      = (state_ff == ST_IDLE) && q_not_empty;
   assign load_out = (state_ff == ST_HOLD) && (!out_valid_ff || rsp_port.ready);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_port.ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               state_in = ST_LOAD;
               phase_in = 1'b0;
            end
         end
         ST_LOAD: begin
            state_in = ST_DIV;
            step_in  = '0;
         end
         ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (last_step) begin
               phase_in = 1'b1;
               state_in = phase_ff ? ST_HOLD : ST_LOAD;
            end
         end
         ST_HOLD: begin
            if (load_out) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= q_data;
      end
      if (state_ff == ST_LOAD) begin
         quo_ff  <= num;
         rem_ff  <= '0;
         neg_ff  <= diff[14];
         zero_ff <= (mag == '0);
      end
      if (state_ff == ST_DIV) begin
         quo_ff <= quo_next;
         rem_ff <= rem_next;
         if (last_step) begin
            if (phase_ff) begin
               normy_ff <= res;
            end else begin
               normx_ff <= res;
            end
         end
      end
      if (load_out) begin
         out_nx_ff   <= normx_ff;
         out_ny_ff   <= normy_ff;
         out_item_ff <= item_ff;
      end
   end

   assign rsp_port.valid        = out_valid_ff;
   assign rsp_port.norm_x       = out_nx_ff;
   assign rsp_port.norm_y       = out_ny_ff;
   assign rsp_port.sample_value = out_item_ff.value;
   assign rsp_port.col          = out_item_ff.col;
   assign rsp_port.row          = out_item_ff.row;

   `EMSN_ASSERT_NEXT(a_load_from_hold, load_out, out_valid_ff, "result load lost")
   `EMSN_ASSERT_NOW(a_pop_idle, pop, state_ff == ST_IDLE && !load_out, "pop outside idle")
endmodule
`default_nettype wire

FILE: src/eroded_mask_sample_normalizer_unit.sv
`default_nettype none
// Binary erosion over a square window with normalized sample output.
// req_port carries one pixel word per handshake (pixel_valid, phase_value)
// in raster order; rsp_port returns one word per core pixel (norm_x, norm_y,
// sample_value, col, row), in raster order. Both use valid/ready.
// Geometry and erosion are to be written through the csr_ APB port only
// while idle; the block itself does not enforce this. Register i sits at byte address 4*i.
// Front end: each pixel word takes a registered read of the flag line
// store and value delay store, then write-back and window test; no new
// word is taken while one is in work. Core pixels enter a 2-entry queue.
// Back end: two 28-step restoring divides (x then y) by 2*radius
// per result; with many core pixels the back end sets the rate
// and the queue fills, pulling req_port.ready low.
// With the back end idle, rsp_port.valid rises once the deciding pixel
// word has passed the front end, the queue and the back end's divides.
// A stalled rsp_port holds its word in the output register; the back end
// finishes the next result and waits, the front end keeps taking pixels
// until the queue is full.
// Reset (synchronous, active high) clears counters, pointer, window and
// queue, and loads register defaults; the line stores need no clearing.
module eroded_mask_sample_normalizer_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   emsn_req_if.sink                                 req_port,
   emsn_rsp_if.source                               rsp_port,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [emsn_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic [31:0]                              csr_prdata,
   output logic                                     csr_pready
);
   import emsn_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] reg_index;
   logic       push, pop, q_room, q_not_empty;
   sample_type push_data, q_data;

   // register file
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_FRAME_WIDTH:  cfg_in.frame_width  = csr_pwdata[10:0];
            REG_FRAME_HEIGHT: cfg_in.frame_height = csr_pwdata[11:0];
            REG_EROSION:      cfg_in.erosion      = csr_pwdata[2:0];
            REG_CENTER_X:     cfg_in.center_x     = csr_pwdata[11:0];
            REG_CENTER_Y:     cfg_in.center_y     = csr_pwdata[12:0];
            REG_RADIUS:       cfg_in.radius       = csr_pwdata[12:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_FRAME_WIDTH:  csr_prdata = 32'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT: csr_prdata = 32'(cfg_ff.frame_height);
         REG_EROSION:      csr_prdata = 32'(cfg_ff.erosion);
         REG_CENTER_X:     csr_prdata = 32'(cfg_ff.center_x);
         REG_CENTER_Y:     csr_prdata = 32'(cfg_ff.center_y);
         REG_RADIUS:       csr_prdata = 32'(cfg_ff.radius);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= 11'd1024;
         cfg_ff.frame_height <= 12'd1024;
         cfg_ff.erosion      <= 3'd0;
         cfg_ff.center_x     <= 12'd1024;
         cfg_ff.center_y     <= 13'd1024;
         cfg_ff.radius       <= 13'd1024;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   emsn_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_port       (req_port),
      .queue_has_room (q_room),
      .push           (push),
      .push_data      (push_data)
   );

   emsn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .has_room  (q_room),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   emsn_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_data      (q_data),
      .pop         (pop),
      .rsp_port    (rsp_port)
   );
endmodule
`default_nettype wire

FILE: sim/emsn_sample_checker.sv
`timescale 1ns / 100ps
// Watches the pixel and sample channels and the register port, predicts each
// core-pixel sample and compares it with what the block returns.
module emsn_sample_checker (
   input  logic        clock,
   input  logic        reset,
   emsn_req_if         req_mon,
   emsn_rsp_if         rsp_mon,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [emsn_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          samples_pending,
   output int          samples_checked
);
   import emsn_pkg::*;

   typedef struct {
      logic [15:0] norm_x;
      logic [15:0] norm_y;
      logic [23:0] value;
      logic [9:0]  col;
      logic [11:0] row;
   } sample_word_type;

   sample_word_type expected_samples[$];

   // register copies
   logic [10:0] frame_w;
   logic [11:0] frame_h;
   logic [2:0]  erode;
   logic [11:0] ctr_x;
   logic [12:0] ctr_y;
   logic [12:0] rad;

   // predictor state
   logic [HIST_BITS-1:0] col_history[MAX_WIDTH];
   logic [23:0]          value_line[DELAY_DEPTH];
   int unsigned          line_ptr;
   logic [HIST_BITS:0]   window_cols[WIN_COLS];
   int unsigned          cur_col, cur_row;

   initial begin
      mismatch_count  = 0;
      samples_checked = 0;
      for (int i = 0; i < MAX_WIDTH; i++) col_history[i] = '0;
      for (int i = 0; i < DELAY_DEPTH; i++) value_line[i] = '0;
   end

   assign samples_pending = expected_samples.size();

   // (2*p - c) * 8192 / r, round half away from zero, saturate to 16 bits
   function automatic logic [15:0] scale_offset(int unsigned p, int unsigned c,
                                                int unsigned r);
      longint num, q;
      longint unsigned mag, m;
      num = (longint'(p) * 2 - longint'(c)) * 8192;
      mag = (num < 0) ? -num : num;
      if (r == 0) begin
         q = (num > 0) ? 32767 : ((num < 0) ? -32768 : 0);
      end else begin
         m = (2 * mag + r) / (2 * r);
         if (m > 32768) m = 32768;
         q = (num < 0) ? -longint'(m) : longint'(m);
         if (q > 32767) q = 32767;
      end
      return q[15:0];
   endfunction

   // one accepted pixel word: update history, maybe queue a sample
   task automatic advance_pixel(logic pv, logic [23:0] val);
      int unsigned w, h, e, x, y, delay, need;
      logic [HIST_BITS:0] colbits;
      logic [23:0] delayed;
      logic core;
      sample_word_type s;
      w = (frame_w == 0) ? 1 : ((frame_w > MAX_WIDTH) ? MAX_WIDTH : frame_w);
      h = (frame_h == 0) ? 1 : frame_h;
      e = (erode > MAX_EROSION) ? MAX_EROSION : erode;
      x = (cur_col >= w) ? 0 : cur_col;
      y = (cur_row >= h) ? 0 : cur_row;

      colbits = {col_history[x], pv};
      col_history[x] = colbits[HIST_BITS-1:0];
      for (int k = WIN_COLS - 1; k > 0; k--) window_cols[k] = window_cols[k-1];
      window_cols[0] = colbits;

      delay = e * w + e;
      delayed = (delay == 0) ? val : value_line[(line_ptr + DELAY_DEPTH - delay) % DELAY_DEPTH];
      value_line[line_ptr] = val;
      line_ptr = (line_ptr + 1) % DELAY_DEPTH;

      if (x >= 2 * e && y >= 2 * e) begin
         need = (1 << (2 * e + 1)) - 1;
         core = 1'b1;
         for (int k = 0; k <= 2 * e; k++)
            if ((window_cols[k] & need) != need) core = 1'b0;
         if (core) begin
            s.norm_x = scale_offset(x - e, ctr_x, rad);
            s.norm_y = scale_offset(y - e, ctr_y, rad);
            s.value  = delayed;
            s.col    = 10'(x - e);
            s.row    = 12'(y - e);
            expected_samples = {expected_samples, s};
         end
      end

      x++;
      if (x >= w) begin
         x = 0;
         y++;
         if (y >= h) y = 0;
      end
      cur_col = x & 32'h3FF;
      cur_row = y & 32'hFFF;
   endtask

   always @(posedge clock) begin
      sample_word_type exp_s;
      if (reset) begin
         frame_w = 11'd1024; frame_h = 12'd1024; erode = 3'd0;
         ctr_x = 12'd1024; ctr_y = 13'd1024; rad = 13'd1024;
         line_ptr = 0; cur_col = 0; cur_row = 0;
         for (int k = 0; k < WIN_COLS; k++) window_cols[k] = '0;
         expected_samples.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_FRAME_WIDTH:  frame_w = csr_pwdata[10:0];
               REG_FRAME_HEIGHT: frame_h = csr_pwdata[11:0];
               REG_EROSION:      erode   = csr_pwdata[2:0];
               REG_CENTER_X:     ctr_x   = csr_pwdata[11:0];
               REG_CENTER_Y:     ctr_y   = csr_pwdata[12:0];
               REG_RADIUS:       rad     = csr_pwdata[12:0];
               default: ;
            endcase
         end
         // compare returned word before queuing this edge's prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_samples.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected sample word col=%0d row=%0d", $time,
                           rsp_mon.col, rsp_mon.row);
            end else begin
               exp_s = expected_samples.pop_front();
               samples_checked++;
               if (rsp_mon.norm_x !== exp_s.norm_x || rsp_mon.norm_y !== exp_s.norm_y ||
                   rsp_mon.sample_value !== exp_s.value || rsp_mon.col !== exp_s.col ||
                   rsp_mon.row !== exp_s.row) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: sample mismatch exp nx=%h ny=%h v=%h c=%0d r=%0d",
                              $time, exp_s.norm_x, exp_s.norm_y, exp_s.value, exp_s.col,
                              exp_s.row);
                     $display("   got nx=%h ny=%h v=%h c=%0d r=%0d",
                              rsp_mon.norm_x, rsp_mon.norm_y,
                              rsp_mon.sample_value, rsp_mon.col, rsp_mon.row);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            advance_pixel(req_mon.pixel_valid, req_mon.phase_value);
      end
   end

endmodule

FILE: sim/tb_eroded_mask_sample_normalizer_unit.sv
`timescale 1ns / 100ps
module tb_eroded_mask_sample_normalizer_unit;
   import emsn_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count, samples_pending, samples_checked;
   int pixels_sent;
   int rsp_hold;      // long receiver hold-off, cycles
   logic steady;      // no idling on either side
   int rsp_gap;

   emsn_req_if req_bus();
   emsn_rsp_if rsp_bus();

   eroded_mask_sample_normalizer_unit dut (
      .clock(clock), .reset(reset),
      .req_port(req_bus), .rsp_port(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   emsn_sample_checker u_checker (
      .clock(clock), .reset(reset), .req_mon(req_bus), .rsp_mon(rsp_bus),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .mismatch_count(mismatch_count), .samples_pending(samples_pending),
      .samples_checked(samples_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #40_000_000;
      $display("eroded_mask_sample_normalizer_unit regression: fail");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // receiver: random stalls plus an occasional long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      rsp_gap = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold = rsp_hold - 1;
         end else if (rsp_gap > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_bus.ready <= 1'b1;
            rsp_gap = steady ? 0 : pick_gap();
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic csr_write(input logic [2:0] idx, input int unsigned data);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr  <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_pixel(input logic pv, input logic [23:0] val);
      int gap;
      req_bus.valid       <= 1'b1;
      req_bus.pixel_valid <= pv;
      req_bus.phase_value <= val;
      do @(posedge clock); while (!req_bus.ready);
      pixels_sent++;
      @(negedge clock);
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // wait until every sample is back and the front end has settled
   task automatic drain_samples();
      req_bus.valid <= 1'b0;
      wait (samples_pending == 0);
      repeat (100) @(negedge clock);
   endtask

   task automatic set_geometry(int w, int h, int e, int cx, int cy, int rad);
      csr_write(REG_FRAME_WIDTH, w);
      csr_write(REG_FRAME_HEIGHT, h);
      csr_write(REG_EROSION, e);
      csr_write(REG_CENTER_X, cx);
      csr_write(REG_CENTER_Y, cy);
      csr_write(REG_RADIUS, rad);
   endtask

   // one setting, then n pixel words; optional hold-off and sender pause
   task automatic run_phase(int w, int h, int e, int cx, int cy, int rad, int n,
                            int valid_pct, int hold, bit pause);
      set_geometry(w, h, e, cx, cy, rad);
      if (hold > 0) rsp_hold = hold;
      for (int i = 0; i < n; i++) begin
         if (pause && i == n / 2) begin
            req_bus.valid <= 1'b0;
            wait (samples_pending == 0);
            @(negedge clock);
         end
         send_pixel($urandom_range(0, 99) < valid_pct, 24'($urandom));
      end
      drain_samples();
   endtask

   initial begin
      int w, h, e, cx, cy, rad, n, ew, ee;
      logic [23:0] edge_vals[4];
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      req_bus.valid = 1'b0; req_bus.pixel_valid = 1'b0; req_bus.phase_value = '0;
      pixels_sent = 0; rsp_hold = 0; steady = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill: nine rows over the twelve columns that later frames decide on,
      // so every history bit they test has been written
      run_phase(12, 9, 0, 12, 9, 24, 12 * 9, 50, 0, 0);

      // directed: small frame, value extremes, saturating offsets
      edge_vals = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF};
      set_geometry(5, 5, 1, 0, 8190, 1);
      for (int i = 0; i < 25; i++)
         send_pixel(i != 12, (i < 8) ? edge_vals[i % 4] : 24'($urandom));
      drain_samples();

      // corner settings: zero width/height, erosion and radius saturation
      run_phase(0, 0, 7, 2048, 0, 0, 20, 90, 0, 0);
      run_phase(2047, 4095, 5, 4095, 8191, 8191, 40, 90, 0, 0);
      // long receiver hold-off while every valid pixel is core
      steady = 1'b1;
      run_phase(6, 6, 0, 6, 6, 8190, 60, 100, 300, 0);
      steady = 1'b0;
      // sender pauses mid-phase until all samples are back
      run_phase(8, 9, 2, 8, 9, 5, 72, 95, 0, 1);

      // random settings, mostly well-formed frames of valid pixels
      for (int p = 0; p < 3; p++) begin
         case ($urandom_range(0, 9))
            0: w = 0;
            1: w = 1;
            default: w = $urandom_range(2, 12);
         endcase
         case ($urandom_range(0, 9))
            0: h = 0;
            1: h = 1;
            default: h = $urandom_range(2, 12);
         endcase
         e = $urandom_range(0, 7);
         case ($urandom_range(0, 3))
            0: cx = 0;
            1: cx = 2048;
            default: cx = $urandom_range(0, 4095);
         endcase
         cx = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2 * 12) : cx;
         case ($urandom_range(0, 3))
            0: cy = 8190;
            1: cy = 0;
            default: cy = $urandom_range(0, 8191);
         endcase
         cy = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2 * 12) : cy;
         case ($urandom_range(0, 5))
            0: rad = 0;
            1: rad = 1;
            2: rad = 8190;
            default: rad = $urandom_range(1, 40);
         endcase
         ew = (w == 0) ? 1 : w;
         ee = (e > 4) ? 4 : e;
         n = ew * (2 * ee + 2);
         if (n < 30) n = 30;
         if (n > 50) n = 50;
         steady = ($urandom_range(0, 3) == 0);
         run_phase(w, h, e, cx, cy, rad, n, (p == 2) ? 50 : 92, 0, 0);
      end
      steady = 1'b0;

      $display("run covered %0d pixel words over 9 register settings", pixels_sent);
      $display("%0d samples compared, %0d mismatches", samples_checked, mismatch_count);
      if (mismatch_count == 0 && samples_pending == 0)
         $display("eroded_mask_sample_normalizer_unit regression: pass");
      else
         $display("eroded_mask_sample_normalizer_unit regression: fail");
      $finish;
   end

endmodule
